// ----- rtl/sdas_pkg.sv -----
// shared constants and helpers for the signed decimal ascii serializer
`default_nettype none
package sdas_pkg;

    // width of one bcd digit
    localparam int unsigned BCD_DIGIT_W = 4;

    // ascii codes
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;

    // decimal digits needed for an unsigned value of the given width
    function automatic int unsigned digit_slots(input int unsigned width);
        return (width * 30103) / 100000 + 1;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sdas_bcd_conv.sv -----
// magnitude extraction and bit-serial shift-add-3 binary to bcd conversion
`default_nettype none
module sdas_bcd_conv #(
    parameter int unsigned VALUE_WIDTH = 32,
    parameter int unsigned NUM_DIGITS  = 10
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_start,
    input  wire logic [VALUE_WIDTH-1:0]                        i_value,
    output logic                                               o_busy,
    output logic                                               o_done,
    output logic                                               o_sign,
    output logic [NUM_DIGITS*sdas_pkg::BCD_DIGIT_W-1:0]        o_bcd
);

    localparam int unsigned BCD_W = NUM_DIGITS * sdas_pkg::BCD_DIGIT_W;
    localparam int unsigned BIT_W = $clog2(VALUE_WIDTH);
    localparam int unsigned DW    = sdas_pkg::BCD_DIGIT_W;

    logic [VALUE_WIDTH-1:0] r_mag,  n_mag;
    logic [BCD_W-1:0]       r_bcd,  n_bcd;
    logic [BIT_W-1:0]       r_bits, n_bits;
    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic                   r_sign, n_sign;
    logic [BCD_W-1:0]       w_adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < NUM_DIGITS; d++) begin
            if (r_bcd[d*DW +: DW] >= DW'(5)) begin
                w_adj[d*DW +: DW] = r_bcd[d*DW +: DW] + DW'(3);
            end else begin
                w_adj[d*DW +: DW] = r_bcd[d*DW +: DW];
            end
        end
    end

    // next state: load on start, then one magnitude bit per cycle
    always_comb begin
        n_mag  = r_mag;
        n_bcd  = r_bcd;
        n_bits = r_bits;
        n_busy = r_busy;
        n_sign = r_sign;
        n_done = 1'b0;
        if (i_start) begin
            n_sign = i_value[VALUE_WIDTH-1];
            n_mag  = i_value[VALUE_WIDTH-1] ? (~i_value + VALUE_WIDTH'(1)) : i_value;
            n_bcd  = '0;
            n_bits = BIT_W'(VALUE_WIDTH - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_bcd  = {w_adj[BCD_W-2:0], r_mag[VALUE_WIDTH-1]};
            n_mag  = {r_mag[VALUE_WIDTH-2:0], 1'b0};
            n_bits = r_bits - BIT_W'(1);
            if (r_bits == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_bcd  <= n_bcd;
        r_bits <= n_bits;
        r_sign <= n_sign;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_sign = r_sign;
    assign o_bcd  = r_bcd;

endmodule
`default_nettype wire

// ----- rtl/sdas_emitter.sv -----
// digit-serial character emitter with leading zero skip and output register
`default_nettype none
module sdas_emitter #(
    parameter int unsigned NUM_DIGITS = 10
) (
    input  wire logic                                          i_clk,
    input  wire logic                                          i_rst_n,
    input  wire logic                                          i_load,
    input  wire logic                                          i_sign,
    input  wire logic [NUM_DIGITS*sdas_pkg::BCD_DIGIT_W-1:0]   i_bcd,
    input  wire logic                                          i_ready,
    output logic                                               o_valid,
    output logic [7:0]                                         o_char,
    output logic                                               o_last,
    output logic                                               o_active
);

    localparam int unsigned DW    = sdas_pkg::BCD_DIGIT_W;
    localparam int unsigned BCD_W = NUM_DIGITS * DW;
    localparam int unsigned CNT_W = $clog2(NUM_DIGITS + 1);

    logic [BCD_W-1:0] r_bcd,     n_bcd;
    logic [CNT_W-1:0] r_cnt,     n_cnt;
    logic             r_sign,    n_sign;
    logic             r_started, n_started;
    logic             r_active,  n_active;
    logic             r_valid,   n_valid;
    logic [7:0]       r_char,    n_char;
    logic             r_last,    n_last;
    logic [DW-1:0]    w_top;
    logic             w_slot_free;
    logic             w_skip;

    assign w_top       = r_bcd[BCD_W-1 -: DW];
    assign w_slot_free = !r_valid || i_ready;
    assign w_skip      = !r_started && (w_top == '0) && (r_cnt > CNT_W'(1));

    // sign first, then digits; leading zeros are dropped one digit a cycle, also while the sign waits
    always_comb begin
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_sign    = r_sign;
        n_started = r_started;
        n_active  = r_active;
        n_valid   = r_valid;
        n_char    = r_char;
        n_last    = r_last;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_bcd     = i_bcd;
            n_sign    = i_sign;
            n_cnt     = CNT_W'(NUM_DIGITS);
            n_started = 1'b0;
            n_active  = 1'b1;
        end else if (r_active) begin
            if (w_skip) begin
                n_bcd = {r_bcd[BCD_W-DW-1:0], {DW{1'b0}}};
                n_cnt = r_cnt - CNT_W'(1);
            end
            if (w_slot_free) begin
                if (r_sign) begin
                    n_char  = sdas_pkg::CHAR_MINUS;
                    n_last  = 1'b0;
                    n_valid = 1'b1;
                    n_sign  = 1'b0;
                end else if (!w_skip) begin
                    n_char    = sdas_pkg::CHAR_ZERO + {{(8-DW){1'b0}}, w_top};
                    n_last    = (r_cnt == CNT_W'(1));
                    n_valid   = 1'b1;
                    n_bcd     = {r_bcd[BCD_W-DW-1:0], {DW{1'b0}}};
                    n_cnt     = r_cnt - CNT_W'(1);
                    n_started = 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        n_active = 1'b0;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_valid  <= 1'b0;
            r_sign   <= 1'b0;
        end else begin
            r_active <= n_active;
            r_valid  <= n_valid;
            r_sign   <= n_sign;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bcd     <= n_bcd;
        r_cnt     <= n_cnt;
        r_started <= n_started;
        r_char    <= n_char;
        r_last    <= n_last;
    end

    assign o_valid  = r_valid;
    assign o_char   = r_char;
    assign o_last   = r_last;
    assign o_active = r_active;

endmodule
`default_nettype wire

// ----- rtl/signed_decimal_ascii_serializer.sv -----
// top level: signed integer in, decimal ascii characters out
// an accepted item is converted bit-serially, then loaded into the emitter, which drops leading
//   zero digits before the sign or first digit is followed by the remaining digits
// a new item is taken only after the previous text is fully queued, so sink stalls also delay it
// once the first digit is out, one character a cycle is presented while the sink takes them
// reset: synchronous active low, clears all valid and busy flags; block starts idle
`default_nettype none
module signed_decimal_ascii_serializer #(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_s_axis_tvalid,
    output logic                                     o_s_axis_tready,
    // [VALUE_WIDTH-1:0] value, zero padded to whole bytes
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    i_s_axis_tdata,
    output logic                                     o_m_axis_tvalid,
    input  wire logic                                i_m_axis_tready,
    // [7:0] ascii_char
    output logic [7:0]                               o_m_axis_tdata,
    output logic                                     o_m_axis_tlast
);

    localparam int unsigned NUM_DIGITS = sdas_pkg::digit_slots(VALUE_WIDTH);
    localparam int unsigned BCD_W      = NUM_DIGITS * sdas_pkg::BCD_DIGIT_W;

    logic             w_accept;
    logic             w_conv_busy;
    logic             w_conv_done;
    logic             w_conv_sign;
    logic [BCD_W-1:0] w_conv_bcd;
    logic             w_emit_active;

    // a new item is taken once the previous text is fully queued
    assign o_s_axis_tready = !w_conv_busy && !w_conv_done && !w_emit_active;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // binary to bcd
    sdas_bcd_conv #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .NUM_DIGITS  (NUM_DIGITS)
    ) u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_accept),
        .i_value (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .o_busy  (w_conv_busy),
        .o_done  (w_conv_done),
        .o_sign  (w_conv_sign),
        .o_bcd   (w_conv_bcd)
    );

    // character stream
    sdas_emitter #(
        .NUM_DIGITS (NUM_DIGITS)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_conv_done),
        .i_sign   (w_conv_sign),
        .i_bcd    (w_conv_bcd),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_char   (o_m_axis_tdata),
        .o_last   (o_m_axis_tlast),
        .o_active (w_emit_active)
    );

    // conversion and emission never overlap
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_conv_busy && w_emit_active))
        else $error("conversion running while emitter active");

    // an accepted item starts the conversion
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_conv_busy)
        else $error("accepted item did not start conversion");

    // a minus sign is never the last character
    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (o_m_axis_tdata == sdas_pkg::CHAR_MINUS)) |-> !o_m_axis_tlast)
        else $error("minus sign marked as last character");

    // conversion finish always hands over to the emitter
    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_conv_done |=> w_emit_active)
        else $error("emitter not started after conversion");

endmodule
`default_nettype wire
